// ===== src/cdt_pkg.sv =====
// Shared types, constants and helpers for the command duplicate table.
// Used by cdt_ctrl, cdt_datapath and the top level command_dedup_table.
// Has no dependencies of its own.
package cdt_pkg;

  // Sizing of the fingerprint store.
  localparam int PAYLOAD_BYTES = 8;
  localparam int HISTORY_DEPTH = 4;
  localparam int RESULT_BYTES  = 8;
  localparam int BYTE_BITS     = 8;

  localparam int DATA_W = 64;
  localparam int LEN_W  = $clog2(PAYLOAD_BYTES + 1);
  localparam int IDX_W  = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;

  // Mask that keeps the stored result bytes only.
  localparam logic [DATA_W-1:0] RESULT_MASK = (RESULT_BYTES >= 8) ? {DATA_W{1'b1}} :
      DATA_W'((65'd1 << (BYTE_BITS * RESULT_BYTES)) - 65'd1);

  // Request codes.
  localparam logic [2:0] REQ_CLASSIFY = 3'd0;
  localparam logic [2:0] REQ_BEGIN    = 3'd1;
  localparam logic [2:0] REQ_COMPLETE = 3'd2;
  localparam logic [2:0] REQ_GET      = 3'd3;
  localparam logic [2:0] REQ_VALIDATE = 3'd4;

  // Classification codes.
  localparam logic [2:0] CLS_INVALID  = 3'd0;
  localparam logic [2:0] CLS_DUP_PEND = 3'd1;
  localparam logic [2:0] CLS_CONFLICT = 3'd2;
  localparam logic [2:0] CLS_DUP_DONE = 3'd3;
  localparam logic [2:0] CLS_BUSY     = 3'd4;
  localparam logic [2:0] CLS_NEW      = 3'd5;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_TYPE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LAST_TYPE  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TEMP_TYPE  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_FREQ   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_TEMP   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_TEMP   = 3'd5;

  // Request word.
  typedef struct packed {
    logic [2:0]        req_type;
    logic [7:0]        flow_id;
    logic [7:0]        msg_type;
    logic [7:0]        payload_len;
    logic [DATA_W-1:0] payload;
    logic [DATA_W-1:0] result_in;
  } req_t;

  // Response word.
  typedef struct packed {
    logic [2:0]        class_code;
    logic              ok;
    logic [DATA_W-1:0] result_out;
  } rsp_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic prep;
    logic step;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic need_walk;
    logic walk_end;
  } dp_status_t;

  // Byte mask covering the first n payload bytes.
  function automatic logic [DATA_W-1:0] len_mask(input logic [7:0] n);
    logic [DATA_W-1:0] m;
    m = '0;
    for (int b = 0; b < DATA_W / BYTE_BITS; b++) begin
      if (b < PAYLOAD_BYTES && n > 8'(b)) begin
        m[b*BYTE_BITS +: BYTE_BITS] = {BYTE_BITS{1'b1}};
      end
    end
    return m;
  endfunction

endpackage

// ===== src/cdt_ctrl.sv =====
// Sequencer of the command duplicate table: capture, evaluate, history walk.
// Depends on cdt_pkg for the command and status structs.
module cdt_ctrl
  import cdt_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  output logic       done,
  output dp_cmd_t    cmd,
  input  dp_status_t st
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_PREP,
    S_WALK
  } state_t;

  state_t state;

  // Commands follow directly from the current state; load also needs start.
  always_comb begin
    cmd.load = (state == S_IDLE) && start;
    cmd.prep = (state == S_PREP);
    cmd.step = (state == S_WALK);
  end

  // State and the registered handshake outputs.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      busy  <= 1'b0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            state <= S_PREP;
            busy  <= 1'b1;
          end
        end
        S_PREP: begin
          if (st.need_walk) begin
            state <= S_WALK;
          end else begin
            state <= S_IDLE;
            busy  <= 1'b0;
            done  <= 1'b1;
          end
        end
        S_WALK: begin
          if (st.walk_end) begin
            state <= S_IDLE;
            busy  <= 1'b0;
            done  <= 1'b1;
          end
        end
        default: begin
          state <= S_IDLE;
          busy  <= 1'b0;
        end
      endcase
    end
  end

  // A strobe is never shown while a request is still in flight.
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result strobe while busy");

  // An accepted request makes the block busy at once.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
      (start && !busy) |=> busy)
    else $error("accepted request did not raise busy");

  // Each strobe closes a request that was in flight.
  a_done_past: assert property (@(posedge clk) disable iff (rst) done |-> $past(busy))
    else $error("result strobe without a request");

  // The walk carries on until the datapath reports its end.
  a_walk_hold: assert property (@(posedge clk) disable iff (rst)
      (state == S_WALK && !st.walk_end) |=> (state == S_WALK))
    else $error("history walk left early");

endmodule

// ===== src/cdt_datapath.sv =====
// Datapath of the command duplicate table: configuration, pending slot,
// history ring and the result registers. Depends on cdt_pkg.
module cdt_datapath
  import cdt_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  req_t                 req,
  input  dp_cmd_t              cmd,
  output dp_status_t           st,
  output rsp_t                 rsp,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // Configuration registers.
  logic [7:0]         first_control_type;
  logic [7:0]         last_control_type;
  logic [7:0]         temp_type_code;
  logic [15:0]        max_frequency;
  logic signed [15:0] min_target_temp;
  logic signed [15:0] max_target_temp;

  // Captured request.
  logic [2:0]        cur_req;
  logic [7:0]        cur_flow;
  logic [7:0]        cur_type;
  logic [LEN_W-1:0]  cur_len;
  logic [DATA_W-1:0] cur_bytes;
  logic [15:0]       cur_raw16;
  logic [DATA_W-1:0] cur_result;
  logic              cur_ctrl;
  logic              cur_fp_ok;

  // Pending slot.
  logic              pending_valid;
  logic [7:0]        pending_flow;
  logic [7:0]        pending_type;
  logic [LEN_W-1:0]  pending_length;
  logic [DATA_W-1:0] pending_bytes;

  // History ring.
  logic [HISTORY_DEPTH-1:0] hist_valid;
  logic [7:0]               hist_flow   [HISTORY_DEPTH];
  logic [7:0]               hist_type   [HISTORY_DEPTH];
  logic [LEN_W-1:0]         hist_length [HISTORY_DEPTH];
  logic [DATA_W-1:0]        hist_bytes  [HISTORY_DEPTH];
  logic [DATA_W-1:0]        hist_result [HISTORY_DEPTH];
  logic [IDX_W-1:0]         ring_index;
  logic [IDX_W-1:0]         walk_idx;

  // Result registers.
  logic [2:0]        cls;
  logic              ok;
  logic [DATA_W-1:0] res;

  // Ring pointer advance with wrap at the history depth.
  function automatic logic [IDX_W-1:0] walk_last_ring(input logic [IDX_W-1:0] r);
    return (r == IDX_W'(HISTORY_DEPTH - 1)) ? '0 : r + IDX_W'(1);
  endfunction

  // Decode of the incoming word before capture.
  logic in_ctrl;
  logic in_fp_ok;
  assign in_ctrl  = (req.msg_type >= first_control_type) && (req.msg_type <= last_control_type);
  assign in_fp_ok = in_ctrl && (req.payload_len <= 8'(PAYLOAD_BYTES));

  // Pending slot comparison.
  logic pend_flow_hit;
  logic pend_equal;
  assign pend_flow_hit = pending_valid && (pending_flow == cur_flow);
  assign pend_equal    = (pending_type == cur_type) && (pending_length == cur_len) &&
                         (pending_bytes == cur_bytes);

  // Comparison against the history entry under the walk pointer.
  logic hist_flow_hit;
  logic hist_equal;
  logic walk_last;
  logic walk_found;
  assign hist_flow_hit = hist_valid[walk_idx] && (hist_flow[walk_idx] == cur_flow);
  assign hist_equal    = (hist_type[walk_idx] == cur_type) &&
                         (hist_length[walk_idx] == cur_len) &&
                         (hist_bytes[walk_idx] == cur_bytes);
  assign walk_last     = (walk_idx == IDX_W'(HISTORY_DEPTH - 1));
  assign walk_found    = (cur_req == REQ_CLASSIFY) ? hist_flow_hit : (hist_flow_hit && hist_equal);

  // Validation of the frequency or temperature parameter.
  logic valid_ok;
  always_comb begin
    if (!cur_ctrl) begin
      valid_ok = 1'b0;
    end else if (cur_type == first_control_type) begin
      valid_ok = (cur_raw16 <= max_frequency);
    end else if (cur_type == temp_type_code) begin
      valid_ok = ($signed(cur_raw16) >= min_target_temp) &&
                 ($signed(cur_raw16) <= max_target_temp);
    end else begin
      valid_ok = 1'b1;
    end
  end

  // Status towards the controller.
  always_comb begin
    st.need_walk = cur_fp_ok &&
                   ((cur_req == REQ_GET) || ((cur_req == REQ_CLASSIFY) && !pend_flow_hit));
    st.walk_end  = walk_found || walk_last;
  end

  assign rsp.class_code = cls;
  assign rsp.ok         = ok;
  assign rsp.result_out = res;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      first_control_type <= 8'd1;
      last_control_type  <= 8'd8;
      temp_type_code     <= 8'd2;
      max_frequency      <= 16'd5000;
      min_target_temp    <= 16'sd0;
      max_target_temp    <= 16'sd1000;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_FIRST_TYPE: first_control_type <= cfg_data[7:0];
        CFG_LAST_TYPE:  last_control_type  <= cfg_data[7:0];
        CFG_TEMP_TYPE:  temp_type_code     <= cfg_data[7:0];
        CFG_MAX_FREQ:   max_frequency      <= cfg_data;
        CFG_MIN_TEMP:   min_target_temp    <= $signed(cfg_data);
        CFG_MAX_TEMP:   max_target_temp    <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

  // Request capture; the fingerprint bytes are masked to the length here.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cur_req    <= req.req_type;
      cur_flow   <= req.flow_id;
      cur_type   <= req.msg_type;
      cur_len    <= req.payload_len[LEN_W-1:0];
      cur_bytes  <= in_fp_ok ? (req.payload & len_mask(req.payload_len)) : '0;
      cur_raw16  <= req.payload[15:0];
      cur_result <= req.result_in & RESULT_MASK;
      cur_ctrl   <= in_ctrl;
      cur_fp_ok  <= in_fp_ok;
    end
  end

  // Result registers and the walk pointer.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cls      <= CLS_INVALID;
      ok       <= 1'b0;
      res      <= '0;
      walk_idx <= '0;
    end else if (cmd.prep) begin
      case (cur_req)
        REQ_CLASSIFY: begin
          if (cur_fp_ok && pend_flow_hit) begin
            cls <= pend_equal ? CLS_DUP_PEND : CLS_CONFLICT;
          end
        end
        REQ_BEGIN:    ok <= !pending_valid && cur_fp_ok;
        REQ_COMPLETE: ok <= pending_valid;
        REQ_VALIDATE: ok <= valid_ok;
        default: ;
      endcase
    end else if (cmd.step) begin
      walk_idx <= walk_idx + IDX_W'(1);
      if (cur_req == REQ_CLASSIFY) begin
        if (hist_flow_hit) begin
          cls <= hist_equal ? CLS_DUP_DONE : CLS_CONFLICT;
        end else if (walk_last) begin
          cls <= pending_valid ? CLS_BUSY : CLS_NEW;
        end
      end else if (walk_found) begin
        ok  <= 1'b1;
        res <= hist_result[walk_idx];
      end
    end
  end

  // Pending slot and ring control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      pending_valid <= 1'b0;
      hist_valid    <= '0;
      ring_index    <= '0;
    end else if (cmd.prep) begin
      if (cur_req == REQ_BEGIN && !pending_valid && cur_fp_ok) begin
        pending_valid <= 1'b1;
      end else if (cur_req == REQ_COMPLETE && pending_valid) begin
        pending_valid          <= 1'b0;
        hist_valid[ring_index] <= 1'b1;
        ring_index <= walk_last_ring(ring_index);
      end
    end
  end

  // Pending and history payload.
  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      if (cur_req == REQ_BEGIN && !pending_valid && cur_fp_ok) begin
        pending_flow   <= cur_flow;
        pending_type   <= cur_type;
        pending_length <= cur_len;
        pending_bytes  <= cur_bytes;
      end else if (cur_req == REQ_COMPLETE && pending_valid) begin
        hist_flow[ring_index]   <= pending_flow;
        hist_type[ring_index]   <= pending_type;
        hist_length[ring_index] <= pending_length;
        hist_bytes[ring_index]  <= pending_bytes;
        hist_result[ring_index] <= cur_result;
      end
    end
  end

  // A completion always leaves the pending slot empty.
  a_complete_clears: assert property (@(posedge clk) disable iff (rst)
      (cmd.prep && cur_req == REQ_COMPLETE && pending_valid) |=> !pending_valid)
    else $error("pending slot survived a completion");

  // The history is only walked when there is a valid fingerprint.
  a_walk_fp: assert property (@(posedge clk) disable iff (rst) cmd.step |-> cur_fp_ok)
    else $error("history walk without a fingerprint");

  // A successful begin fills the pending slot.
  a_begin_fills: assert property (@(posedge clk) disable iff (rst)
      (cmd.prep && cur_req == REQ_BEGIN && !pending_valid && cur_fp_ok) |=> pending_valid)
    else $error("begin did not fill the pending slot");

endmodule

// ===== src/command_dedup_table.sv =====
// Top level of the command duplicate table.
// Joins cdt_ctrl and cdt_datapath; types and constants come from cdt_pkg.
//
// Usage:
//   A request word is taken on req at a clock edge where start is high and
//   busy is low. It classifies, begins, completes, looks up or validates one
//   command against the pending slot and the ring of completed commands.
//   Exactly one response word follows on rsp, valid for the single cycle in
//   which done is high; the receiver cannot hold it off.
//   Configuration registers are written through cfg_valid, cfg_index, cfg_data;
//   cfg_ready is always high. Write only while idle; the block does not check.
// Sequencing:
//   Each request passes through S_PREP. done is raised from there for begin,
//   complete, validate, unknown requests, get requests with an invalid message
//   and classifications settled by the pending slot or by an invalid message.
//   Classify and get result otherwise walk the history in S_WALK one entry a
//   cycle, stopping at the entry sought or at the last entry. busy falls with
//   done, so the next request may be taken in the cycle that done is shown.
// Reset:
//   rst is synchronous; it empties the pending slot and the history and
//   restores the configuration defaults. No clearing pass is needed.
module command_dedup_table
  import cdt_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  req_t                  req,
  output logic                  done,
  output rsp_t                  rsp,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  dp_cmd_t    cmd;
  dp_status_t st;

  // Configuration words are always taken.
  assign cfg_ready = 1'b1;

  // Sequencer.
  cdt_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .done  (done),
    .cmd   (cmd),
    .st    (st)
  );

  // Fingerprint store and result logic.
  cdt_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cmd       (cmd),
    .st        (st),
    .rsp       (rsp),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

endmodule

// ===== dv/tb.sv =====
// Self-checking testbench for command_dedup_table: directed and random requests
// are checked word by word against a predictor of the pending slot and the ring.
// Depends on cdt_pkg and the RTL under src only.
module tb
  import cdt_pkg::*;
();

  // Predictor of the duplicate table, with the queue of responses it expects.
  class dedup_table_model;
    logic [7:0]         first_type, last_type, temp_type;
    logic [15:0]        max_freq;
    logic signed [15:0] min_temp, max_temp;
    logic               pend_valid;
    logic [7:0]         pend_flow, pend_mtype, pend_len;
    logic [DATA_W-1:0]  pend_bytes;
    logic               hist_valid [HISTORY_DEPTH];
    logic [7:0]         hist_flow [HISTORY_DEPTH];
    logic [7:0]         hist_mtype [HISTORY_DEPTH];
    logic [7:0]         hist_len [HISTORY_DEPTH];
    logic [DATA_W-1:0]  hist_bytes [HISTORY_DEPTH];
    logic [DATA_W-1:0]  hist_result [HISTORY_DEPTH];
    int                 ring_pos;
    rsp_t               expected_rsp_q [$];
    int unsigned        errors;

    function new();
      first_type = 8'd1;
      last_type  = 8'd8;
      temp_type  = 8'd2;
      max_freq   = 16'd5000;
      min_temp   = 16'sd0;
      max_temp   = 16'sd1000;
      pend_valid = 1'b0;
      pend_flow  = '0;
      pend_mtype = '0;
      pend_len   = '0;
      pend_bytes = '0;
      for (int i = 0; i < HISTORY_DEPTH; i++) begin
        hist_valid[i]  = 1'b0;
        hist_flow[i]   = '0;
        hist_mtype[i]  = '0;
        hist_len[i]    = '0;
        hist_bytes[i]  = '0;
        hist_result[i] = '0;
      end
      ring_pos = 0;
      errors   = 0;
    endfunction

    function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        CFG_FIRST_TYPE: first_type = val[7:0];
        CFG_LAST_TYPE:  last_type  = val[7:0];
        CFG_TEMP_TYPE:  temp_type  = val[7:0];
        CFG_MAX_FREQ:   max_freq   = val;
        CFG_MIN_TEMP:   min_temp   = val;
        CFG_MAX_TEMP:   max_temp   = val;
        default: ;
      endcase
    endfunction

    function logic is_control(logic [7:0] mtype);
      return mtype >= first_type && mtype <= last_type;
    endfunction

    function logic entry_equal(int i, req_t r, logic [DATA_W-1:0] fp_bytes);
      return hist_mtype[i] == r.msg_type && hist_len[i] == r.payload_len &&
             hist_bytes[i] == fp_bytes;
    endfunction

    // Works out the response word and moves the table state on by one request.
    function rsp_t predict_response(req_t r);
      rsp_t               o;
      logic               fp_ok, found;
      logic [DATA_W-1:0]  fp_bytes;
      logic signed [15:0] temp;
      o = '0;
      found = 1'b0;
      fp_ok = r.payload_len <= PAYLOAD_BYTES && is_control(r.msg_type);
      // Bytes at or past the length are zero in a fingerprint.
      fp_bytes = '0;
      if (fp_ok) begin
        for (int b = 0; b < PAYLOAD_BYTES; b++) begin
          if (b < r.payload_len) fp_bytes[b*BYTE_BITS +: BYTE_BITS] = r.payload[b*BYTE_BITS +: BYTE_BITS];
        end
      end
      case (r.req_type)
        REQ_CLASSIFY: begin
          if (!fp_ok) begin
            o.class_code = CLS_INVALID;
          end else if (pend_valid && pend_flow == r.flow_id) begin
            o.class_code = (pend_mtype == r.msg_type && pend_len == r.payload_len &&
                            pend_bytes == fp_bytes) ? CLS_DUP_PEND : CLS_CONFLICT;
          end else begin
            for (int i = 0; i < HISTORY_DEPTH; i++) begin
              if (!found && hist_valid[i] && hist_flow[i] == r.flow_id) begin
                found = 1'b1;
                o.class_code = entry_equal(i, r, fp_bytes) ? CLS_DUP_DONE : CLS_CONFLICT;
              end
            end
            if (!found) o.class_code = pend_valid ? CLS_BUSY : CLS_NEW;
          end
        end
        REQ_BEGIN: begin
          if (!pend_valid && fp_ok) begin
            pend_valid = 1'b1;
            pend_flow  = r.flow_id;
            pend_mtype = r.msg_type;
            pend_len   = r.payload_len;
            pend_bytes = fp_bytes;
            o.ok = 1'b1;
          end
        end
        REQ_COMPLETE: begin
          if (pend_valid) begin
            hist_valid[ring_pos]  = 1'b1;
            hist_flow[ring_pos]   = pend_flow;
            hist_mtype[ring_pos]  = pend_mtype;
            hist_len[ring_pos]    = pend_len;
            hist_bytes[ring_pos]  = pend_bytes;
            hist_result[ring_pos] = r.result_in & RESULT_MASK;
            ring_pos   = (ring_pos + 1) % HISTORY_DEPTH;
            pend_valid = 1'b0;
            pend_flow  = '0;
            pend_mtype = '0;
            pend_len   = '0;
            pend_bytes = '0;
            o.ok = 1'b1;
          end
        end
        REQ_GET: begin
          if (fp_ok) begin
            for (int i = 0; i < HISTORY_DEPTH; i++) begin
              if (!found && hist_valid[i] && hist_flow[i] == r.flow_id &&
                  entry_equal(i, r, fp_bytes)) begin
                found = 1'b1;
                o.ok = 1'b1;
                o.result_out = hist_result[i];
              end
            end
          end
        end
        REQ_VALIDATE: begin
          // The frequency check takes priority when both type codes agree.
          if (is_control(r.msg_type)) begin
            temp = r.payload[15:0];
            if (r.msg_type == first_type) o.ok = r.payload[15:0] <= max_freq;
            else if (r.msg_type == temp_type) o.ok = temp >= min_temp && temp <= max_temp;
            else o.ok = 1'b1;
          end
        end
        default: ;
      endcase
      return o;
    endfunction

    function void note_request(req_t r);
      expected_rsp_q.push_back(predict_response(r));
    endfunction

    task report(string what);
      $display("mismatch at %0t: %s", $time, what);
      errors++;
    endtask

    task check_response(rsp_t got);
      rsp_t want;
      if (expected_rsp_q.size() == 0) begin
        report($sformatf("response word with none expected: class %0d ok %0d result %h",
                         got.class_code, got.ok, got.result_out));
        return;
      end
      want = expected_rsp_q.pop_front();
      if (got.class_code !== want.class_code)
        report($sformatf("class_code %0d, expected %0d", got.class_code, want.class_code));
      if (got.ok !== want.ok)
        report($sformatf("ok %0d, expected %0d", got.ok, want.ok));
      if (got.result_out !== want.result_out)
        report($sformatf("result_out %h, expected %h", got.result_out, want.result_out));
    endtask
  endclass

  logic                  clk = 1'b0;
  logic                  rst, start, busy, done, cfg_valid, cfg_ready;
  req_t                  req;
  rsp_t                  rsp;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  dedup_table_model sb = new();
  req_t             recent_msgs [$];
  int               idle_pct;

  command_dedup_table dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .req(req), .done(done), .rsp(rsp),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Every response word is checked at the edge that ends its cycle.
  always @(posedge clk) begin
    if (!rst && done) sb.check_response(rsp);
  end

  // Presents one request word, with an occasional gap first, and waits for it to be taken.
  task automatic send_request(input req_t r);
    @(negedge clk);
    if ($urandom_range(99) < idle_pct) begin
      start = 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
    start = 1'b1;
    req   = r;
    do @(posedge clk); while (busy);
    sb.note_request(r);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    do @(posedge clk); while (!cfg_ready);
    sb.set_register(idx, val);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic write_all(input int f, input int l, input int t, input int mf, input int mn,
                           input int mx);
    write_register(CFG_FIRST_TYPE, 16'(f));
    write_register(CFG_LAST_TYPE, 16'(l));
    write_register(CFG_TEMP_TYPE, 16'(t));
    write_register(CFG_MAX_FREQ, 16'(mf));
    write_register(CFG_MIN_TEMP, 16'(mn));
    write_register(CFG_MAX_TEMP, 16'(mx));
  endtask

  // Stops issuing and lets every outstanding response word come back.
  task automatic drain();
    @(negedge clk);
    start = 1'b0;
    while (sb.expected_rsp_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  function automatic req_t cmd(input logic [2:0] op, input logic [7:0] flow,
                               input logic [7:0] mtype, input logic [7:0] len,
                               input logic [63:0] payload, input logic [63:0] result);
    req_t r;
    r.req_type    = op;
    r.flow_id     = flow;
    r.msg_type    = mtype;
    r.payload_len = len;
    r.payload     = payload;
    r.result_in   = result;
    return r;
  endfunction

  // Mostly well-formed traffic on a few flows, reusing recent commands so that
  // duplicates, conflicts and history hits are common.
  function automatic req_t random_request();
    req_t       r;
    int         roll;
    logic [2:0] op;
    roll = $urandom_range(99);
    if (roll < 30) op = REQ_CLASSIFY;
    else if (roll < 50) op = REQ_BEGIN;
    else if (roll < 65) op = REQ_COMPLETE;
    else if (roll < 80) op = REQ_GET;
    else if (roll < 95) op = REQ_VALIDATE;
    else op = 3'($urandom_range(5, 7));
    if (recent_msgs.size() > 0 && $urandom_range(99) < 60) begin
      r = recent_msgs[$urandom_range(recent_msgs.size() - 1)];
      if ($urandom_range(3) == 0) r.payload[63:32] = $urandom();
      if ($urandom_range(7) == 0) r.msg_type = 8'($urandom_range(sb.last_type, sb.first_type));
      if ($urandom_range(9) == 0) r.payload_len = 8'($urandom_range(0, 8));
    end else begin
      r.flow_id     = ($urandom_range(99) < 70) ? 8'($urandom_range(0, 3)) : 8'($urandom());
      r.msg_type    = ($urandom_range(99) < 80) ? 8'($urandom_range(sb.last_type, sb.first_type))
                                                 : 8'($urandom());
      r.payload_len = ($urandom_range(99) < 85) ? 8'($urandom_range(0, 8))
                                                 : 8'($urandom_range(9, 255));
      r.payload     = {$urandom(), $urandom()};
    end
    r.result_in = {$urandom(), $urandom()};
    r.req_type  = op;
    // Validation values sit on the range boundaries half of the time.
    if (op == REQ_VALIDATE && $urandom_range(1) == 0) begin
      case ($urandom_range(5))
        0: r.payload[15:0] = sb.max_freq;
        1: r.payload[15:0] = sb.max_freq + 16'd1;
        2: r.payload[15:0] = sb.min_temp;
        3: r.payload[15:0] = sb.min_temp - 16'sd1;
        4: r.payload[15:0] = sb.max_temp;
        default: r.payload[15:0] = sb.max_temp + 16'sd1;
      endcase
    end
    if (op == REQ_BEGIN) begin
      recent_msgs.push_back(r);
      if (recent_msgs.size() > 8) void'(recent_msgs.pop_front());
    end
    return r;
  endfunction

  initial begin
    int f, l, mn, items;
    rst       = 1'b1;
    start     = 1'b0;
    req       = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    idle_pct  = 15;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed part under the reset settings.
    send_request(cmd(REQ_CLASSIFY, 8'h20, 8'd3, 8'd2, 64'hFFFF_FFFF_FFFF_A55A, '0));
    send_request(cmd(REQ_CLASSIFY, 8'h20, 8'd0, 8'd2, 64'h0, '0));
    send_request(cmd(REQ_CLASSIFY, 8'h20, 8'd3, 8'd9, 64'h0, '0));
    send_request(cmd(REQ_BEGIN, 8'h20, 8'd3, 8'd255, 64'h0, '0));
    send_request(cmd(REQ_BEGIN, 8'h20, 8'd3, 8'd2, 64'hFFFF_FFFF_FFFF_A55A, '0));
    send_request(cmd(REQ_BEGIN, 8'h21, 8'd3, 8'd2, 64'h0, '0));
    // Bytes past the length do not count towards the fingerprint.
    send_request(cmd(REQ_CLASSIFY, 8'h20, 8'd3, 8'd2, 64'h0000_0000_0000_A55A, '0));
    send_request(cmd(REQ_CLASSIFY, 8'h20, 8'd4, 8'd2, 64'hA55A, '0));
    send_request(cmd(REQ_CLASSIFY, 8'hFF, 8'd3, 8'd2, 64'hA55A, '0));
    send_request(cmd(REQ_COMPLETE, 8'h00, 8'd0, 8'd0, 64'h0, '1));
    send_request(cmd(REQ_COMPLETE, 8'h00, 8'd0, 8'd0, 64'h0, 64'h1234));
    send_request(cmd(REQ_CLASSIFY, 8'h20, 8'd3, 8'd2, 64'hA55A, '0));
    send_request(cmd(REQ_CLASSIFY, 8'h20, 8'd3, 8'd3, 64'hA55A, '0));
    send_request(cmd(REQ_GET, 8'h20, 8'd3, 8'd2, 64'h77A55A, '0));
    send_request(cmd(REQ_GET, 8'h20, 8'd3, 8'd1, 64'h5A, '0));
    send_request(cmd(REQ_BEGIN, 8'h00, 8'd8, 8'd8, '1, '0));
    send_request(cmd(REQ_COMPLETE, 8'h00, 8'd0, 8'd0, 64'h0, 64'h0123_4567_89AB_CDEF));
    send_request(cmd(REQ_BEGIN, 8'hFF, 8'd1, 8'd0, 64'hDEAD_BEEF, '0));
    send_request(cmd(REQ_CLASSIFY, 8'hFF, 8'd1, 8'd0, 64'h1, '0));
    send_request(cmd(REQ_VALIDATE, 8'h00, 8'd1, 8'd0, 64'd5000, '0));
    send_request(cmd(REQ_VALIDATE, 8'h00, 8'd1, 8'd0, 64'd5001, '0));
    send_request(cmd(REQ_VALIDATE, 8'h00, 8'd2, 8'd0, 64'hFFFF, '0));
    send_request(cmd(REQ_VALIDATE, 8'h00, 8'd2, 8'd0, 64'd1000, '0));
    send_request(cmd(REQ_VALIDATE, 8'h00, 8'd5, 8'd0, 64'h0, '0));
    send_request(cmd(REQ_VALIDATE, 8'h00, 8'd9, 8'd0, 64'h0, '0));
    send_request(cmd(3'd7, 8'hFF, 8'd3, 8'd2, '1, '1));
    send_request(cmd(3'd5, 8'h20, 8'd3, 8'd2, 64'hA55A, '0));

    // Random phases, each under its own register settings.
    for (int p = 0; p < 6; p++) begin
      drain();
      items = 200;
      case (p)
        0: write_all(1, 8, 2, 5000, 0, 1000);
        1: write_all(0, 255, 0, 0, -32768, 32767);
        2: write_all(255, 255, 255, 65535, 32767, 32767);
        3: begin
          // An empty control range makes every message invalid, so keep this one short.
          write_all(10, 3, 5, 1234, -500, -100);
          items = 60;
        end
        4: begin
          f  = $urandom_range(0, 20);
          l  = f + $urandom_range(0, 30);
          mn = $urandom_range(0, 2000) - 1000;
          write_all(f, l, $urandom_range(l, f), $urandom_range(0, 65535), mn,
                    mn + $urandom_range(0, 3000));
        end
        default: write_all(1, 8, 2, 5000, 0, 1000);
      endcase
      // One phase runs back to back with no gaps at all.
      idle_pct = (p == 4) ? 0 : 15;
      repeat (items) send_request(random_request());
    end

    drain();
    if (sb.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
